// ----- design/lcfc_pkg.sv -----
// Shared constants, status codes and the CRC-32 byte update for the
// length-prefixed frame checker. No dependencies.
`default_nettype none

package lcfc_pkg;

  localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
  localparam logic [31:0] CRC_ONES = 32'hFFFF_FFFF;
  localparam int unsigned CRC_BYTES = 4;

  localparam int unsigned TDATA_W = 32;

  typedef enum logic [1:0] {
    ST_PENDING = 2'd0,
    ST_GOOD    = 2'd1,
    ST_BAD_CRC = 2'd2,
    ST_TRUNC   = 2'd3
  } frame_status_t;

  // Reflected CRC-32, one byte, bit at a time (eight narrow dependent steps).
  function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] data);
    logic [31:0] c;
    c = crc ^ {24'd0, data};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ----- design/length_crc32_frame_checker.sv -----
// Top level of the length-prefixed frame checker with CRC-32.
// Depends on lcfc_pkg for status codes, constants and the CRC byte update.
//
//   channel | direction | tdata                   | tuser         | tlast
//   s_*     | in        | [7:0] rx_byte           | -             | buffer_end
//   m_*     | out       | [7:0] payload_byte,     | payload_valid | frame_done
//           |           | [9:8] frame_status,     |               |
//           |           | [25:10] payload_length  |               |
//
// One item per cycle while the output is not stalled, and each result is registered.
// The parse state and CRC update sit between the input and the result
// register, and a new item enters whenever the result register is empty or
// is being taken in the same cycle. A stall on m_tready holds the result and
// stops input. Reset (rst, synchronous) clears the parser and the result valid.
`default_nettype none

module length_crc32_frame_checker
  import lcfc_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                s_tvalid,
  output logic                     s_tready,
  input  wire logic [7:0]          s_tdata,   // [7:0] rx_byte
  input  wire logic                s_tlast,
  output logic                     m_tvalid,
  input  wire logic                m_tready,
  output logic [TDATA_W-1:0]       m_tdata,   // [7:0] payload_byte, [9:8] frame_status,
                                              // [25:10] payload_length, rest zero
  output logic                     m_tuser,   // [0] payload_valid
  output logic                     m_tlast
);

  typedef enum logic [2:0] {
    PH_LEN_HI  = 3'd0,
    PH_LEN_LO  = 3'd1,
    PH_PAYLOAD = 3'd2,
    PH_CRC     = 3'd3,
    PH_DONE    = 3'd4
  } phase_t;

  phase_t        phase, phase_next;
  logic [15:0]   frame_length, frame_length_next;
  logic [15:0]   byte_count, byte_count_next;
  logic [31:0]   running_crc, running_crc_next;
  logic [31:0]   received_crc, received_crc_next;

  logic          pv, done;
  logic [7:0]    pb;
  frame_status_t status;
  logic [15:0]   plen;
  logic          len_known;
  logic [15:0]   count_inc;
  logic          accept;

  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;
  assign count_inc = byte_count + 16'd1;

  always_comb begin
    phase_next        = phase;
    frame_length_next = frame_length;
    byte_count_next   = byte_count;
    running_crc_next  = running_crc;
    received_crc_next = received_crc;
    pv        = 1'b0;
    pb        = 8'd0;
    done      = 1'b0;
    status    = ST_PENDING;
    plen      = 16'd0;
    len_known = (phase == PH_PAYLOAD) || (phase == PH_CRC) || (phase == PH_DONE);

    unique case (phase)
      PH_LEN_HI: begin
        frame_length_next = {s_tdata, 8'd0};
        phase_next        = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        frame_length_next = {frame_length[15:8], s_tdata};
        len_known         = 1'b1;
        byte_count_next   = 16'd0;
        running_crc_next  = CRC_ONES;
        received_crc_next = 32'd0;
        phase_next = ({frame_length[15:8], s_tdata} == 16'd0) ? PH_CRC : PH_PAYLOAD;
      end
      PH_PAYLOAD: begin
        pv               = 1'b1;
        pb               = s_tdata;
        running_crc_next = crc32_byte(running_crc, s_tdata);
        byte_count_next  = count_inc;
        if (count_inc >= frame_length) begin
          byte_count_next = 16'd0;
          phase_next      = PH_CRC;
        end
      end
      PH_CRC: begin
        received_crc_next = {received_crc[23:0], s_tdata};
        byte_count_next   = count_inc;
        if (count_inc >= 16'(CRC_BYTES)) begin
          done       = 1'b1;
          status     = ((~running_crc) == {received_crc[23:0], s_tdata}) ? ST_GOOD
                                                                         : ST_BAD_CRC;
          plen       = frame_length;
          phase_next = PH_DONE;
        end
      end
      default: ;  // frame finished: trailing bytes are ignored
    endcase

    if (s_tlast) begin
      if (!done && (phase_next != PH_DONE)) begin
        done   = 1'b1;
        status = ST_TRUNC;
        plen   = len_known ? frame_length_next : 16'd0;
      end
      // The last byte of the buffer re-arms the parser.
      phase_next        = PH_LEN_HI;
      frame_length_next = 16'd0;
      byte_count_next   = 16'd0;
      running_crc_next  = CRC_ONES;
      received_crc_next = 32'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_LEN_HI;
      frame_length <= 16'd0;
      byte_count   <= 16'd0;
      running_crc  <= CRC_ONES;
      received_crc <= 32'd0;
      m_tvalid     <= 1'b0;
    end else begin
      if (accept) begin
        phase        <= phase_next;
        frame_length <= frame_length_next;
        byte_count   <= byte_count_next;
        running_crc  <= running_crc_next;
        received_crc <= received_crc_next;
        m_tvalid     <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      m_tdata <= {{(TDATA_W - 26){1'b0}}, plen, status, pb};
      m_tuser <= pv;
      m_tlast <= done;
    end
  end

endmodule

`default_nettype wire

// ----- design/lcfc_checker.sv -----
// Port-level checker for the frame checker, bound to the top level.
// Depends on lcfc_pkg for the status codes and the result word width.
`default_nettype none

module lcfc_checker
  import lcfc_pkg::*;
(
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               s_tready,
  input wire logic               m_tvalid,
  input wire logic               m_tready,
  input wire logic [TDATA_W-1:0] m_tdata,
  input wire logic               m_tuser,
  input wire logic               m_tlast
);

  // A result that is not the end of a frame carries no status and no length.
  property p_idle_fields;
    @(posedge clk) disable iff (rst)
      (m_tvalid && !m_tlast) |-> (m_tdata[25:8] == 18'd0);
  endproperty
  a_idle_fields: assert property (p_idle_fields) else $error("status or length without frame end");

  // A finished frame always reports a real status.
  property p_done_status;
    @(posedge clk) disable iff (rst)
      (m_tvalid && m_tlast) |-> (m_tdata[9:8] != ST_PENDING);
  endproperty
  a_done_status: assert property (p_done_status) else $error("frame end with pending status");

  // Non-payload results carry a zero data byte.
  property p_no_payload;
    @(posedge clk) disable iff (rst)
      (m_tvalid && !m_tuser) |-> (m_tdata[7:0] == 8'd0);
  endproperty
  a_no_payload: assert property (p_no_payload) else $error("data byte without payload flag");

  // Input is refused only while a result waits on a stalled output.
  property p_ready;
    @(posedge clk) disable iff (rst)
      !s_tready |-> (m_tvalid && !m_tready);
  endproperty
  a_ready: assert property (p_ready) else $error("input stalled without output stall");

  // A stalled result holds its payload.
  property p_hold;
    @(posedge clk) disable iff (rst)
      (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)
                                   && $stable(m_tuser));
  endproperty
  a_hold: assert property (p_hold) else $error("stalled result changed");

endmodule

bind length_crc32_frame_checker lcfc_checker u_lcfc_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);

`default_nettype wire
